// ===== rtl/core/jhs_pkg.sv =====
// ============================================================================
// jhs_pkg
// Types and constants shared by the JPEG header scanner: beat payloads,
// parser phases, result status codes and marker code values.
// ============================================================================
package jhs_pkg;

    // One byte of the file on the input channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } jhs_in_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FRAME_OK  = 2'd0,
        ST_NO_PREFIX = 2'd1,
        ST_EARLY_END = 2'd2
    } jhs_status_t;

    // One result beat
    typedef struct packed {
        jhs_status_t status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  sample_precision;
        logic [7:0]  component_count;
        logic [25:0] horiz_dpi_q8;
        logic [25:0] vert_dpi_q8;
    } jhs_out_t;

    // Parser phases
    typedef enum logic [3:0] {
        PH_PREFIX = 4'd0,
        PH_CODE   = 4'd1,
        PH_LEN_HI = 4'd2,
        PH_LEN_LO = 4'd3,
        PH_SIG    = 4'd4,
        PH_JFIF   = 4'd5,
        PH_SOF    = 4'd6,
        PH_SKIP   = 4'd7,
        PH_DONE   = 4'd8
    } jhs_phase_t;

    // Marker codes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_STUFF  = 8'h00;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_RST7   = 8'hD7;
    localparam logic [7:0] MARK_APP0   = 8'hE0;
    localparam logic [7:0] MARK_SOF_LO = 8'hC0;
    localparam logic [7:0] MARK_SOF_HI = 8'hCF;
    localparam logic [7:0] MARK_DHT    = 8'hC4;
    localparam logic [7:0] MARK_JPG    = 8'hC8;
    localparam logic [7:0] MARK_DAC    = 8'hCC;

    // JFIF identifier length and field positions after it
    localparam logic [2:0] SIG_LEN      = 3'd5;
    localparam logic [2:0] JF_UNITS     = 3'd2;
    localparam logic [2:0] JF_XDENS_HI  = 3'd3;
    localparam logic [2:0] JF_XDENS_LO  = 3'd4;
    localparam logic [2:0] JF_YDENS_HI  = 3'd5;
    localparam logic [2:0] JF_YDENS_LO  = 3'd6;

    // Frame header field positions
    localparam logic [2:0] SOF_PREC     = 3'd0;
    localparam logic [2:0] SOF_H_HI     = 3'd1;
    localparam logic [2:0] SOF_H_LO     = 3'd2;
    localparam logic [2:0] SOF_W_HI     = 3'd3;
    localparam logic [2:0] SOF_W_LO     = 3'd4;

    // Density unit codes and default DPI (72.0 in Q8)
    localparam logic [7:0]  UNITS_INCH  = 8'd1;
    localparam logic [7:0]  UNITS_CM    = 8'd2;
    localparam logic [25:0] DPI_DEFAULT = 26'd18432;

    // d*2.54*256 = (d*65024 + 50) / 100; the divide is (x>>2)/25 done as a
    // multiply by ceil(2^35/25) and a shift, exact for any 30-bit x
    localparam logic [31:0] CM_ROUND    = 32'd50;
    localparam logic [30:0] DIV25_MULT  = 31'd1374389535;
    localparam int          DIV25_SHIFT = 35;

    // Expected byte of the "JFIF\0" identifier
    function automatic logic [7:0] jfif_sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h4A;
            3'd1:    val = 8'h46;
            3'd2:    val = 8'h49;
            3'd3:    val = 8'h46;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Start-of-frame codes: C0..CF without DHT, JPG and DAC
    function automatic logic is_frame_marker(input logic [7:0] code);
        return (code >= MARK_SOF_LO) && (code <= MARK_SOF_HI) &&
               (code != MARK_DHT) && (code != MARK_JPG) && (code != MARK_DAC);
    endfunction

endpackage

// ===== rtl/core/jpeg_header_scanner_top.sv =====
// ============================================================================
// jpeg_header_scanner_top
// Walks the marker segments of a JPEG byte stream up to the first frame
// header and reports its size, precision, component count and JFIF DPI.
// ============================================================================
// Usage:
//   Byte channel (byte_valid/byte_ready/byte_data) takes one file byte per
//   beat; end_of_file marks the last byte, after which the parser starts
//   afresh on the next file.
//   Result channel (result_valid/result_ready/result_data) gives at most one
//   beat per file: the frame header fields, a missing-prefix error or an
//   early end of stream. Non-status fields are zero on an error.
//   Throughput is one byte per cycle except while a result waits unread.
//   A result appears in the result register the cycle after its byte is taken.
//   DPI conversion runs in a two-stage multiply pipeline beside the parser;
//   at least nine bytes separate the last density byte from any frame
//   result, so its output is always settled in time.
//   If the receiver stalls, the result is held and byte_ready drops only
//   while a waiting result could be overwritten; with result_ready high a
//   byte is taken in the same cycle the previous result leaves.
//   Reset puts the parser back at the marker-prefix search with no JFIF
//   density seen and the result register empty.
// ============================================================================
module jpeg_header_scanner_top
    import jhs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  jhs_in_t  byte_data,
    output logic     result_valid,
    input  logic     result_ready,
    output jhs_out_t result_data
);

    // Parser state
    jhs_phase_t  phase_reg,     phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [2:0]  field_reg,     field_next;
    logic [7:0]  marker_reg,    marker_next;
    logic [7:0]  high_reg,      high_next;
    logic        sig_ok_reg,    sig_ok_next;
    logic        jfif_seen_reg, jfif_seen_next;
    logic [7:0]  units_reg,     units_next;
    logic [15:0] xdens_reg,     xdens_next;
    logic [15:0] ydens_reg,     ydens_next;
    logic [15:0] width_reg,     width_next;
    logic [15:0] height_reg,    height_next;
    logic [7:0]  precision_reg, precision_next;

    // DPI pipeline, lane 0 horizontal, lane 1 vertical
    logic [15:0] lane_dens [2];
    logic [31:0] scaled_reg [2];
    logic [31:0] scaled_next [2];
    logic [25:0] dpi_reg [2];
    logic [25:0] dpi_next [2];
    logic [60:0] div_prod [2];

    // Result register
    logic        result_valid_reg;
    jhs_out_t    result_reg;
    jhs_out_t    result_next;
    logic        emit;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] pair;
    logic [15:0] body_len;
    logic [15:0] dec_rem;

    assign byte_ready   = !result_valid_reg || result_ready;
    assign accept       = byte_valid && byte_ready;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    assign b        = byte_data.data_byte;
    assign pair     = {high_reg, b};
    assign body_len = (pair >= 16'd2) ? (pair - 16'd2) : 16'd0;
    assign dec_rem  = (remaining_reg != 16'd0) ? (remaining_reg - 16'd1) : 16'd0;

    // Next state and result for one byte
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        field_next     = field_reg;
        marker_next    = marker_reg;
        high_next      = high_reg;
        sig_ok_next    = sig_ok_reg;
        jfif_seen_next = jfif_seen_reg;
        units_next     = units_reg;
        xdens_next     = xdens_reg;
        ydens_next     = ydens_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        precision_next = precision_reg;
        emit           = 1'b0;
        result_next    = '0;

        case (phase_reg)
            PH_PREFIX:
            begin
                if (b == MARK_PREFIX)
                begin
                    phase_next = PH_CODE;
                end
                else
                begin
                    emit               = 1'b1;
                    result_next.status = ST_NO_PREFIX;
                    phase_next         = PH_DONE;
                end
            end
            PH_CODE:
            begin
                if (b != MARK_STUFF && b != MARK_PREFIX)
                begin
                    marker_next = b;
                    if (b inside {MARK_SOI, [MARK_RST0:MARK_RST7]})
                        phase_next = PH_PREFIX;
                    else
                        phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                high_next  = b;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                remaining_next = body_len;
                field_next     = 3'd0;
                if (is_frame_marker(marker_reg))
                begin
                    phase_next = PH_SOF;
                end
                else if (marker_reg == MARK_APP0 && body_len > 16'd5)
                begin
                    sig_ok_next = 1'b1;
                    phase_next  = PH_SIG;
                end
                else
                begin
                    phase_next = (body_len == 16'd0) ? PH_PREFIX : PH_SKIP;
                end
            end
            PH_SIG:
            begin
                sig_ok_next = sig_ok_reg && (b == jfif_sig_byte(field_reg));
                field_next  = field_reg + 3'd1;
                if (field_next >= SIG_LEN)
                begin
                    remaining_next = (remaining_reg >= 16'd5) ?
                                     (remaining_reg - 16'd5) : 16'd0;
                    field_next     = 3'd0;
                    if (sig_ok_next)
                        phase_next = PH_JFIF;
                    else
                        phase_next = (remaining_next == 16'd0) ? PH_PREFIX : PH_SKIP;
                end
            end
            PH_JFIF:
            begin
                remaining_next = dec_rem;
                case (field_reg)
                    JF_UNITS:
                    begin
                        units_next     = b;
                        jfif_seen_next = 1'b1;
                    end
                    JF_XDENS_HI, JF_YDENS_HI: high_next  = b;
                    JF_XDENS_LO:              xdens_next = pair;
                    JF_YDENS_LO:              ydens_next = pair;
                    default:                  ;
                endcase
                if (field_reg >= JF_YDENS_LO)
                begin
                    field_next = 3'd0;
                    phase_next = (dec_rem == 16'd0) ? PH_PREFIX : PH_SKIP;
                end
                else
                begin
                    field_next = field_reg + 3'd1;
                end
            end
            PH_SOF:
            begin
                field_next = field_reg + 3'd1;
                case (field_reg)
                    SOF_PREC:           precision_next = b;
                    SOF_H_HI, SOF_W_HI: high_next      = b;
                    SOF_H_LO:           height_next    = pair;
                    SOF_W_LO:           width_next     = pair;
                    default:
                    begin
                        emit                         = 1'b1;
                        result_next.status           = ST_FRAME_OK;
                        result_next.image_width      = width_reg;
                        result_next.image_height     = height_reg;
                        result_next.sample_precision = precision_reg;
                        result_next.component_count  = b;
                        result_next.horiz_dpi_q8     = dpi_reg[0];
                        result_next.vert_dpi_q8      = dpi_reg[1];
                        field_next                   = field_reg;
                        phase_next                   = PH_DONE;
                    end
                endcase
            end
            PH_SKIP:
            begin
                remaining_next = dec_rem;
                if (dec_rem == 16'd0)
                    phase_next = PH_PREFIX;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Last byte of the file: report an unfinished scan, then restart
        if (byte_data.end_of_file)
        begin
            if (!emit && phase_next != PH_DONE)
            begin
                emit               = 1'b1;
                result_next        = '0;
                result_next.status = ST_EARLY_END;
            end
            phase_next     = PH_PREFIX;
            remaining_next = 16'd0;
            field_next     = 3'd0;
            sig_ok_next    = 1'b1;
            jfif_seen_next = 1'b0;
        end
    end

    // Parser control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            remaining_reg <= 16'd0;
            field_reg     <= 3'd0;
            sig_ok_reg    <= 1'b1;
            jfif_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            field_reg     <= field_next;
            sig_ok_reg    <= sig_ok_next;
            jfif_seen_reg <= jfif_seen_next;
        end
    end

    // Header field holds, not reset and loaded only on accepted bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            marker_reg    <= marker_next;
            high_reg      <= high_next;
            units_reg     <= units_next;
            xdens_reg     <= xdens_next;
            ydens_reg     <= ydens_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            precision_reg <= precision_next;
        end
    end

    // DPI conversion: stage 1 scales by 65024 and rounds, stage 2 divides
    // by 100 and picks the unit rule
    assign lane_dens[0] = xdens_reg;
    assign lane_dens[1] = ydens_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            scaled_next[i] = (32'(lane_dens[i]) << 16) - (32'(lane_dens[i]) << 9)
                             + CM_ROUND;
            div_prod[i]    = 61'(scaled_reg[i][31:2]) * 61'(DIV25_MULT);
            if (!jfif_seen_reg)
                dpi_next[i] = 26'd0;
            else if (units_reg == UNITS_INCH)
                dpi_next[i] = {2'b00, lane_dens[i], 8'h00};
            else if (units_reg == UNITS_CM)
                dpi_next[i] = div_prod[i][DIV25_SHIFT +: 26];
            else
                dpi_next[i] = DPI_DEFAULT;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            scaled_reg[i] <= scaled_next[i];
            dpi_reg[i]    <= dpi_next[i];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            result_reg <= result_next;
    end

`ifndef SYNTHESIS
    // The last byte of a file always returns the parser to the prefix search
    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_data.end_of_file |=> phase_reg == PH_PREFIX && !jfif_seen_reg)
        else $error("parser did not restart after end of file");

    // A frame result can only come from the frame header phase
    a_frame_src: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && result_next.status == ST_FRAME_OK |-> phase_reg == PH_SOF)
        else $error("frame result outside frame header phase");

    // Once finished, bytes before the end of the file produce no result
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_DONE && !byte_data.end_of_file |-> !emit)
        else $error("result emitted after scan finished");

    // A new result beat follows an accepted byte
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(accept))
        else $error("result appeared without an accepted byte");

    // Identifier index stays inside the identifier
    a_sig_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SIG |-> field_reg < SIG_LEN)
        else $error("identifier index out of range");
`endif

endmodule
